// ----- rtl/core/dtet_pkg.sv -----
// Shared constants, register indexes and arithmetic helpers for the POSIX timekeeper.
package dtet_pkg;

  localparam int unsigned CfgDataWidth   = 8;
  localparam int unsigned CfgIndexWidth  = 3;
  localparam int unsigned CountWidth     = 32;
  localparam int unsigned UptimeWidth    = 31;
  localparam int unsigned EpochWidth     = 32;
  localparam int unsigned CfgSettleDepth = 5;

  localparam logic [5:0] ResetSecond  = 6'd0;
  localparam logic [5:0] ResetMinute  = 6'd0;
  localparam logic [4:0] ResetHour    = 5'd0;
  localparam logic [4:0] ResetDay     = 5'd1;
  localparam logic [3:0] ResetMonth   = 4'd1;
  localparam logic [6:0] ResetYear    = 7'd70;
  localparam logic [4:0] ResetCentury = 5'd19;
  localparam logic [7:0] ResetOffset  = 8'd4;

  localparam logic signed [12:0] BaseYear      = 13'sd1900;
  localparam logic signed [12:0] EpochYear     = 13'sd70;
  localparam logic signed [12:0] LeapBias4     = 13'sd69;
  localparam logic signed [12:0] LeapBias100   = 13'sd1;
  localparam logic signed [12:0] LeapBias400   = 13'sd299;
  localparam logic [31:0]        SecPerMin     = 32'd60;
  localparam logic [31:0]        SecPerHour    = 32'd3600;
  localparam logic [31:0]        SecPerDay     = 32'd24 * SecPerHour;
  localparam logic [31:0]        SecPerYear    = 32'd365 * SecPerDay;
  localparam logic [22:0]        Recip100      = 23'd1311;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SECOND  = 3'd0,
    REG_MINUTE  = 3'd1,
    REG_HOUR    = 3'd2,
    REG_DAY     = 3'd3,
    REG_MONTH   = 3'd4,
    REG_YEAR    = 3'd5,
    REG_CENTURY = 3'd6,
    REG_OFFSET  = 3'd7
  } cfg_reg_t;

  // Floor of m / 100 for m below 4096; the reciprocal is exact over that range.
  function automatic logic [5:0] div100(input logic [11:0] m);
    logic [22:0] p;
    p = {11'b0, m} * Recip100;
    return p[22:17];
  endfunction

  function automatic logic [11:0] magnitude(input logic signed [12:0] x);
    logic [12:0] n;
    n = 13'(-x);
    return x[12] ? n[11:0] : x[11:0];
  endfunction

  // Signed quotients that truncate toward zero.
  function automatic logic signed [10:0] sdiv4(input logic signed [12:0] x);
    logic [11:0] mag;
    logic signed [10:0] q;
    mag = magnitude(x);
    q = {1'b0, mag[11:2]};
    return x[12] ? -q : q;
  endfunction

  function automatic logic signed [6:0] sdiv100(input logic signed [12:0] x);
    logic signed [6:0] q;
    q = {1'b0, div100(magnitude(x))};
    return x[12] ? -q : q;
  endfunction

  function automatic logic signed [6:0] sdiv400(input logic signed [12:0] x);
    logic [11:0] mag;
    logic signed [6:0] q;
    mag = magnitude(x);
    q = {1'b0, div100({2'b0, mag[11:2]})};
    return x[12] ? -q : q;
  endfunction

  function automatic logic is_leap(input logic [11:0] year);
    logic [5:0]  q;
    logic [11:0] r;
    q = div100(year);
    r = 12'(year - {6'b0, q} * 12'd100);
    return (year[1:0] == 2'b00) && ((r != 12'd0) || (q[1:0] == 2'b00));
  endfunction

  // Days in the year before the first of the month; month zero counts none.
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/core/date_to_epoch_timekeeper.sv -----
// Top level of the POSIX seconds-since-epoch timekeeper.
//
//   Channel   Direction  Handshake                 Payload
//   in        sink       in_valid / in_stall       advance
//   out       source     out_valid / out_stall     uptime_seconds, epoch_seconds
//   cfg       sink       cfg_write (no handshake)  cfg_index, cfg_data
//
// Every input transfer yields one registered result, and a new input can be taken every cycle
// while in_stall is low: the tick counter and one 32-bit add sit between the counter and result
// registers. After reset and after each configuration write a five-stage pipeline rebuilds the
// start epoch, and in_stall is held high while it refills.
// A stalled result is parked in a one-entry skid register, so one more input is taken while
// the output waits; in_stall also rises when that entry is full. Reset is synchronous.
module date_to_epoch_timekeeper (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [dtet_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [dtet_pkg::CfgDataWidth-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 advance,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dtet_pkg::UptimeWidth-1:0]     uptime_seconds,
  output logic [dtet_pkg::EpochWidth-1:0]      epoch_seconds
);

  // Configuration registers.
  logic [5:0] start_second;
  logic [5:0] start_minute;
  logic [4:0] start_hour;
  logic [4:0] start_day;
  logic [3:0] start_month;
  logic [6:0] start_year;
  logic [4:0] start_century;
  logic [7:0] offset_seconds;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_second   <= dtet_pkg::ResetSecond;
      start_minute   <= dtet_pkg::ResetMinute;
      start_hour     <= dtet_pkg::ResetHour;
      start_day      <= dtet_pkg::ResetDay;
      start_month    <= dtet_pkg::ResetMonth;
      start_year     <= dtet_pkg::ResetYear;
      start_century  <= dtet_pkg::ResetCentury;
      offset_seconds <= dtet_pkg::ResetOffset;
    end else if (cfg_write) begin
      case (dtet_pkg::cfg_reg_t'(cfg_index))
        dtet_pkg::REG_SECOND:  start_second   <= cfg_data[5:0];
        dtet_pkg::REG_MINUTE:  start_minute   <= cfg_data[5:0];
        dtet_pkg::REG_HOUR:    start_hour     <= cfg_data[4:0];
        dtet_pkg::REG_DAY:     start_day      <= cfg_data[4:0];
        dtet_pkg::REG_MONTH:   start_month    <= cfg_data[3:0];
        dtet_pkg::REG_YEAR:    start_year     <= cfg_data[6:0];
        dtet_pkg::REG_CENTURY: start_century  <= cfg_data[4:0];
        dtet_pkg::REG_OFFSET:  offset_seconds <= cfg_data;
        default: ;
      endcase
    end
  end

  // The settle shift register marks cycles in which the start-epoch pipeline
  // still holds values from before the latest write. Reset fills it so the
  // reset values propagate before the first transfer.
  logic [dtet_pkg::CfgSettleDepth-1:0] settle;
  logic                                busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= '1;
    end else begin
      settle <= {settle[dtet_pkg::CfgSettleDepth-2:0], cfg_write};
    end
  end

  assign busy = |settle;

  // Start-epoch pipeline. It runs every cycle from the registers; the stages
  // carry no reset because the settle logic covers their fill time.
  //
  // Stage 1: full year, signed years since 1900, and seconds into the day
  // with the correction offset folded in.
  logic [11:0]        full_year;
  logic signed [12:0] yr;
  logic [17:0]        sod_off;

  logic [11:0]        full_year_next;
  logic [17:0]        sod_off_next;

  assign full_year_next = 12'({7'b0, start_century} * 12'd100) + {5'b0, start_year};
  assign sod_off_next   = {12'b0, start_second}
                        + 18'({12'b0, start_minute} * 18'(dtet_pkg::SecPerMin))
                        + 18'({13'b0, start_hour} * 18'(dtet_pkg::SecPerHour))
                        + {10'b0, offset_seconds};

  always_ff @(posedge clk) begin
    full_year <= full_year_next;
    yr        <= $signed({1'b0, full_year_next}) - dtet_pkg::BaseYear;
    sod_off   <= sod_off_next;
  end

  // Stage 2: leap-day count since the epoch and day of the year, both signed
  // since a day of zero or an early year gives negative values.
  logic signed [10:0] leaps;
  logic signed [9:0]  yday;
  logic signed [12:0] yr_s2;
  logic [17:0]        sod_off_s2;

  logic signed [10:0] leaps_next;
  logic signed [9:0]  yday_next;
  logic               leap_fix;

  assign leaps_next = dtet_pkg::sdiv4(yr - dtet_pkg::LeapBias4)
                    - 11'(dtet_pkg::sdiv100(yr - dtet_pkg::LeapBias100))
                    + 11'(dtet_pkg::sdiv400(yr + dtet_pkg::LeapBias400));

  // The current year's own leap day counts only once February is over.
  assign leap_fix  = (start_month > 4'd2) && dtet_pkg::is_leap(full_year);
  assign yday_next = $signed({1'b0, dtet_pkg::days_before(start_month)})
                   + $signed({9'b0, leap_fix})
                   + $signed({5'b0, start_day})
                   - 10'sd1;

  always_ff @(posedge clk) begin
    leaps      <= leaps_next;
    yday       <= yday_next;
    yr_s2      <= yr;
    sod_off_s2 <= sod_off;
  end

  // Stage 3: total day count and years since 1970.
  logic signed [11:0] days;
  logic signed [12:0] yrs70;
  logic [17:0]        sod_off_s3;

  always_ff @(posedge clk) begin
    days       <= {{2{yday[9]}}, yday} + {leaps[10], leaps};
    yrs70      <= yr_s2 - dtet_pkg::EpochYear;
    sod_off_s3 <= sod_off_s2;
  end

  // Stage 4: the two products, taken modulo 2^32.
  logic [31:0] day_secs;
  logic [31:0] year_secs;
  logic [17:0] sod_off_s4;

  always_ff @(posedge clk) begin
    day_secs   <= {{20{days[11]}}, days} * dtet_pkg::SecPerDay;
    year_secs  <= {{19{yrs70[12]}}, yrs70} * dtet_pkg::SecPerYear;
    sod_off_s4 <= sod_off_s3;
  end

  // Stage 5: the start epoch that each result adds uptime to.
  logic [dtet_pkg::EpochWidth-1:0] base_epoch;

  always_ff @(posedge clk) begin
    base_epoch <= day_secs + year_secs + {14'b0, sod_off_s4};
  end

  // Item path: tick counter, result register and skid entry.
  logic [dtet_pkg::CountWidth-1:0]  half_second_count;
  logic [dtet_pkg::CountWidth-1:0]  half_second_count_next;
  logic [dtet_pkg::UptimeWidth-1:0] up_next;
  logic [dtet_pkg::EpochWidth-1:0]  epoch_next;
  logic                             in_xfer;
  logic                             out_free;
  logic                             skid_valid;
  logic [dtet_pkg::UptimeWidth-1:0] skid_uptime;
  logic [dtet_pkg::EpochWidth-1:0]  skid_epoch;

  assign in_stall               = busy || skid_valid;
  assign in_xfer                = in_valid && !in_stall;
  assign out_free               = !out_valid || !out_stall;
  assign half_second_count_next = half_second_count + {31'b0, advance};
  assign up_next                = half_second_count_next[dtet_pkg::CountWidth-1:1];
  assign epoch_next             = base_epoch + {1'b0, up_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      half_second_count <= '0;
      out_valid         <= 1'b0;
      skid_valid        <= 1'b0;
    end else begin
      if (in_xfer) begin
        half_second_count <= half_second_count_next;
      end
      if (out_free) begin
        out_valid  <= skid_valid || in_xfer;
        skid_valid <= 1'b0;
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        uptime_seconds <= skid_uptime;
        epoch_seconds  <= skid_epoch;
      end else if (in_xfer) begin
        uptime_seconds <= up_next;
        epoch_seconds  <= epoch_next;
      end
    end else if (in_xfer) begin
      skid_uptime <= up_next;
      skid_epoch  <= epoch_next;
    end
  end

`ifndef ASSERT_OFF
  // A configuration write must hold off input until the start epoch is rebuilt.
  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("input taken while start epoch was being rebuilt");

  // A parked result always sits behind a result that is on the port.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register is empty");

  // Each input transfer moves the tick counter by exactly the advance bit.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (half_second_count == $past(half_second_count) + {31'b0, $past(advance)}))
    else $error("tick counter did not follow the accepted advance bit");
`endif

endmodule

// ----- sim/date_to_epoch_timekeeper_tb.sv -----
// Self-checking testbench for the POSIX seconds-since-epoch timekeeper.
`timescale 1ns / 100ps

module date_to_epoch_timekeeper_tb;

  // The block answers each transfer from a registered result, with one skid entry behind it.
  localparam int unsigned SettleCycles = 8;
  // Longest stretch without any transfer before the run is declared hung. The
  // deliberate receiver hold-off is far shorter than this.
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned HoldOffLen   = 300;
  localparam int unsigned ReportLimit  = 10;
  localparam logic [31:0] DaySeconds   = 32'd86400;
  localparam logic [31:0] YearSeconds  = 32'd31536000;

  // Register image of the start date and the correction offset.
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
    logic [4:0] century;
    logic [7:0] offset;
  } start_date_t;

  // One clock reading as the block reports it.
  typedef struct packed {
    logic [dtet_pkg::UptimeWidth-1:0] uptime;
    logic [dtet_pkg::EpochWidth-1:0]  epoch;
  } clock_reading_t;

  logic                               clk;
  logic                               rst;
  logic                               cfg_write;
  logic [dtet_pkg::CfgIndexWidth-1:0] cfg_index;
  logic [dtet_pkg::CfgDataWidth-1:0]  cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic                               advance;
  logic                               out_valid;
  logic                               out_stall;
  logic [dtet_pkg::UptimeWidth-1:0]   uptime_seconds;
  logic [dtet_pkg::EpochWidth-1:0]    epoch_seconds;

  // Shared between the stimulus, the receiver and the checker.
  clock_reading_t due_readings[$];
  start_date_t    date_image;
  logic [31:0]    half_ticks;
  int unsigned    fault_count;
  int unsigned    quiet_cycles;
  int unsigned    hold_off_request;
  bit             calm;

  date_to_epoch_timekeeper dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .uptime_seconds (uptime_seconds),
    .epoch_seconds  (epoch_seconds)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the start epoch
  // ---------------------------------------------------------------------------

  function automatic bit gregorian_leap(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Days of a common year that lie before the first of the given month.
  function automatic int unsigned days_to_month(input int unsigned mon);
    case (mon)
      1:       return 0;
      2:       return 31;
      3:       return 59;
      4:       return 90;
      5:       return 120;
      6:       return 151;
      7:       return 181;
      8:       return 212;
      9:       return 243;
      10:      return 273;
      11:      return 304;
      12:      return 334;
      default: return 0;
    endcase
  endfunction

  // POSIX seconds of the start date plus the correction offset. Years are
  // counted from 1900 as a signed value, and the leap corrections divide it
  // truncating toward zero, so dates before 1970 come out wrapped. Month zero
  // counts no months, months past twelve count as December, and a day of zero
  // simply steps one day back. Everything wraps modulo 2^32.
  function automatic logic [31:0] posix_base_epoch(input start_date_t d);
    int unsigned mon;
    int unsigned full_year;
    int unsigned yday;
    int          yrs;
    int          leap_days;
    mon       = (d.month > 4'd12) ? 12 : d.month;
    full_year = d.century * 100 + d.year;
    yrs       = int'(full_year) - 1900;
    yday      = days_to_month(mon);
    if (mon > 2 && gregorian_leap(full_year)) begin
      yday = yday + 1;
    end
    yday      = yday + d.day - 1;
    leap_days = (yrs - 69) / 4 - (yrs - 1) / 100 + (yrs + 299) / 400;
    return 32'(d.offset) + 32'(d.second) + 32'(d.minute) * 32'd60
         + 32'(d.hour) * 32'd3600 + yday * DaySeconds
         + 32'(yrs - 70) * YearSeconds + 32'(leap_days) * DaySeconds;
  endfunction

  // ---------------------------------------------------------------------------
  // Checker: one process sees every transfer on all three ports at the rising
  // edge, so the order of prediction and comparison never depends on the
  // scheduler. Register writes update the image of the start date, input
  // transfers add their advance bit to the tick count and queue a reading, and output
  // transfers are compared against the oldest queued reading.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    clock_reading_t want;
    logic [31:0]    whole_secs;
    bit             moved;
    if (rst) begin
      date_image   = '{second: dtet_pkg::ResetSecond, minute: dtet_pkg::ResetMinute,
                       hour: dtet_pkg::ResetHour, day: dtet_pkg::ResetDay,
                       month: dtet_pkg::ResetMonth, year: dtet_pkg::ResetYear,
                       century: dtet_pkg::ResetCentury, offset: dtet_pkg::ResetOffset};
      half_ticks   = '0;
      quiet_cycles = 0;
      due_readings.delete();
    end else begin
      moved = 1'b0;
      if (cfg_write) begin
        case (dtet_pkg::cfg_reg_t'(cfg_index))
          dtet_pkg::REG_SECOND:  date_image.second  = cfg_data[5:0];
          dtet_pkg::REG_MINUTE:  date_image.minute  = cfg_data[5:0];
          dtet_pkg::REG_HOUR:    date_image.hour    = cfg_data[4:0];
          dtet_pkg::REG_DAY:     date_image.day     = cfg_data[4:0];
          dtet_pkg::REG_MONTH:   date_image.month   = cfg_data[3:0];
          dtet_pkg::REG_YEAR:    date_image.year    = cfg_data[6:0];
          dtet_pkg::REG_CENTURY: date_image.century = cfg_data[4:0];
          dtet_pkg::REG_OFFSET:  date_image.offset  = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        if (advance) begin
          half_ticks = half_ticks + 32'd1;
        end
        whole_secs  = half_ticks >> 1;
        want.uptime = whole_secs[dtet_pkg::UptimeWidth-1:0];
        want.epoch  = posix_base_epoch(date_image) + whole_secs;
        due_readings.push_back(want);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (due_readings.size() == 0) begin
          fault_count++;
          if (fault_count <= ReportLimit) begin
            $display("%0t: result with nothing outstanding: uptime %0d epoch %0d",
                     $realtime, uptime_seconds, epoch_seconds);
          end
        end else begin
          want = due_readings.pop_front();
          if (uptime_seconds !== want.uptime || epoch_seconds !== want.epoch) begin
            fault_count++;
            if (fault_count <= ReportLimit) begin
              $display({"%0t: reading mismatch: uptime %0d (expected %0d), ",
                        "epoch %0d (expected %0d)"},
                       $realtime, uptime_seconds, want.uptime, epoch_seconds, want.epoch);
            end
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: a run with no transfer for this long is hung.
  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls at random about one cycle in ten unless the test asks for
  // a calm stretch. A hold-off request keeps the output stalled for a counted
  // number of cycles so that the skid entry fills and the input backs up.
  // ---------------------------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request != 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_request) @(negedge clk);
        hold_off_request = 0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks. All of them start and end at a falling edge.
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the falling edge after its transfer,
  // leaving valid high so a following item can go out without a gap.
  task automatic send_tick(input logic adv);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    advance  <= adv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering and waits until every queued reading has been returned.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_readings.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input dtet_pkg::cfg_reg_t idx, input logic [7:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
  endtask

  // Writes all eight registers with raw bytes once the block is idle; the
  // block keeps only the low bits that each register holds.
  task automatic load_date(input logic [7:0] sec, minute, hour, day,
                           input logic [7:0] month, year, cent, offs);
    wait_for_results();
    write_reg(dtet_pkg::REG_SECOND, sec);
    write_reg(dtet_pkg::REG_MINUTE, minute);
    write_reg(dtet_pkg::REG_HOUR, hour);
    write_reg(dtet_pkg::REG_DAY, day);
    write_reg(dtet_pkg::REG_MONTH, month);
    write_reg(dtet_pkg::REG_YEAR, year);
    write_reg(dtet_pkg::REG_CENTURY, cent);
    write_reg(dtet_pkg::REG_OFFSET, offs);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the start is 1970-01-01 with the offset of four seconds.
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_for_results();
  endtask

  // Every register at all ones (masked to its width, month past December) and
  // at all zeros (day and month zero, century zero).
  task automatic test_field_extremes();
    load_date(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_tick(1'b1);
    send_tick(1'b0);
    load_date(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_for_results();
  endtask

  // The leap day of the start year counts only after February, and century
  // years are leap years only when divisible by 400.
  task automatic test_leap_years_and_months();
    load_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd0, 8'd20, 8'd0);     // 2000-03-01
    send_tick(1'b1);
    load_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd0, 8'd19, 8'd0);     // 1900-03-01
    send_tick(1'b0);
    load_date(8'd45, 8'd30, 8'd12, 8'd29, 8'd2, 8'd24, 8'd20, 8'd4); // 2024-02-29
    send_tick(1'b1);
    load_date(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd0, 8'd21, 8'd0); // 2100-12-31
    send_tick(1'b1);
    // Month thirteen must land on December.
    load_date(8'd7, 8'd8, 8'd9, 8'd10, 8'd13, 8'd24, 8'd20, 8'd1);
    send_tick(1'b0);
    // Day zero steps back into the previous year.
    load_date(8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd70, 8'd19, 8'd0);
    send_tick(1'b1);
    wait_for_results();
  endtask

  // Dates before the epoch make the year count negative and the sum wrap.
  task automatic test_years_before_epoch();
    load_date(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd69, 8'd19, 8'd0); // 1969-12-31
    send_tick(1'b0);
    load_date(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd19, 8'd0);       // 1901-01-01
    send_tick(1'b1);
    load_date(8'd15, 8'd20, 8'd6, 8'd4, 8'd7, 8'd60, 8'd19, 8'd200);  // 1960-07-04
    send_tick(1'b1);
    wait_for_results();
  endtask

  // Phases of random ticks, each after a fresh start date: about half of them
  // plausible calendar dates, the rest raw bytes that exercise the masking and
  // the out-of-range handling. One phase runs with no idling on either side.
  task automatic test_random_traffic(input int unsigned phases, input int unsigned per_phase);
    int unsigned tick_pct;
    for (int p = 0; p < phases; p++) begin
      if ($urandom_range(0, 1) == 0) begin
        load_date(8'($urandom_range(0, 59)), 8'($urandom_range(0, 59)),
                  8'($urandom_range(0, 23)), 8'($urandom_range(1, 31)),
                  8'($urandom_range(1, 12)), 8'($urandom_range(0, 99)),
                  8'($urandom_range(19, 21)), 8'($urandom_range(0, 255)));
      end else begin
        load_date(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      calm     = (p == 1);
      tick_pct = $urandom_range(30, 95);
      repeat (per_phase) send_tick($urandom_range(0, 99) < tick_pct);
      // The sender holds back here until every reading of the phase is in.
      wait_for_results();
      calm = 1'b0;
    end
  endtask

  // The receiver stalls for a long stretch while items keep coming, so the
  // skid entry fills and the block pushes back on its input.
  task automatic test_output_backpressure();
    hold_off_request = HoldOffLen;
    repeat (40) send_tick(1'($urandom_range(0, 1)));
    wait_for_results();
  endtask

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    advance          = 1'b0;
    fault_count      = 0;
    quiet_cycles     = 0;
    hold_off_request = 0;
    calm             = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_leap_years_and_months();
    test_years_before_epoch();
    test_random_traffic(4, 100);
    test_output_backpressure();
    test_random_traffic(4, 100);

    // Let any stray result show up before deciding.
    wait_for_results();
    repeat (SettleCycles) @(negedge clk);
    if (fault_count == 0 && due_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
